>>> design/esp_pkg.sv
`default_nettype none
package esp_pkg;
    localparam int unsigned ValW = 16;
    localparam int unsigned SumW = ValW + 1;

    // Buckets only narrow the sum lookup; an exact compare of the sum gives the same
    // answer, so the store is searched by sum alone.
    localparam int unsigned HashBuckets = 100;

    typedef struct packed {
        logic load;
        logic clear;
        logic start_walk;
        logic read_pair;
        logic scan_step;
        logic record;
        logic advance;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic scan_done;
        logic sum_hit;
        logic disjoint;
    } t_status;
endpackage
`default_nettype wire

>>> design/equal_sum_pair_finder_core.sv
// Channel   Direction  Handshake         Payload
// request   in         start / busy      i_element_value, i_last_element
// result    out        o_valid strobe    o_pair_found, four values, o_list_overflow
//
// A non-last request is taken in the same cycle that start is high while busy is low.
// The last request starts the pair walk, which scans the stored sums for each pair
// through the single read port of the sum store. Reset is synchronous and clears the
// controller and counters; memories are not cleared. The result strobe lasts one cycle
// and cannot be held off.
`default_nettype none
module equal_sum_pair_finder_core #(
    parameter int unsigned MAX_ELEMENTS    = 16,
    parameter int unsigned MAX_SUM_ENTRIES = 120
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_element_value,
    input  wire logic               i_last_element,
    output logic                    o_valid,
    output logic                    o_pair_found,
    output logic signed [15:0]      o_first_left,
    output logic signed [15:0]      o_first_right,
    output logic signed [15:0]      o_second_left,
    output logic signed [15:0]      o_second_right,
    output logic                    o_list_overflow
);
    import esp_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    done;

    esp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_last(i_last_element),
        .i_status(status), .o_cmd(cmd), .o_busy(busy), .o_done(done));

    esp_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS), .MAX_SUM_ENTRIES(MAX_SUM_ENTRIES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_value(i_element_value), .o_status(status),
        .o_found(o_pair_found), .o_first_left, .o_first_right, .o_second_left,
        .o_second_right, .o_overflow(o_list_overflow));

    assign o_valid = done;

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !busy) else $error("load while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("busy after result");
endmodule
`default_nettype wire

>>> design/esp_ram.sv
`default_nettype none
module esp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/esp_datapath.sv
`default_nettype none
module esp_datapath #(
    parameter int unsigned MAX_ELEMENTS    = 16,
    parameter int unsigned MAX_SUM_ENTRIES = 120
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire esp_pkg::t_cmd                 i_cmd,
    input  wire logic signed [15:0]            i_value,
    output esp_pkg::t_status                   o_status,
    output logic                               o_found,
    output logic signed [15:0]                 o_first_left,
    output logic signed [15:0]                 o_first_right,
    output logic signed [15:0]                 o_second_left,
    output logic signed [15:0]                 o_second_right,
    output logic                               o_overflow
);
    import esp_pkg::*;

    localparam int unsigned IdxW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned EntW = $clog2(MAX_SUM_ENTRIES + 1);
    localparam int unsigned AdrW = (MAX_SUM_ENTRIES > 1) ? $clog2(MAX_SUM_ENTRIES) : 1;
    localparam int unsigned RamD = (MAX_SUM_ENTRIES > 1) ? MAX_SUM_ENTRIES : 2;
    localparam int unsigned EW   = SumW + 2 * ValW;

    logic [CntW-1:0] r_count;
    logic            r_ovf;
    logic [IdxW-1:0] r_i, r_j;
    logic [EntW-1:0] r_entries, r_k;
    logic signed [ValW-1:0] r_a, r_b;
    logic signed [SumW-1:0] r_sum;
    logic r_found;
    logic signed [ValW-1:0] r_fl, r_fr, r_sl, r_sr;

    logic [ValW-1:0] w_a, w_b;
    logic [EW-1:0]   w_ent;
    logic signed [SumW-1:0] e_sum;
    logic signed [ValW-1:0] e_l, e_r;

    // Two element copies give both pair values in one read.
    esp_ram #(.WIDTH(ValW), .DEPTH(MAX_ELEMENTS)) u_ea (
        .i_clk, .i_we(i_cmd.load && (r_count < CntW'(MAX_ELEMENTS))),
        .i_waddr(r_count[IdxW-1:0]), .i_wdata(i_value),
        .i_raddr(r_i), .o_rdata(w_a));
    esp_ram #(.WIDTH(ValW), .DEPTH(MAX_ELEMENTS)) u_eb (
        .i_clk, .i_we(i_cmd.load && (r_count < CntW'(MAX_ELEMENTS))),
        .i_waddr(r_count[IdxW-1:0]), .i_wdata(i_value),
        .i_raddr(r_j), .o_rdata(w_b));
    esp_ram #(.WIDTH(EW), .DEPTH(RamD)) u_sums (
        .i_clk, .i_we(i_cmd.record && (r_entries < EntW'(MAX_SUM_ENTRIES))),
        .i_waddr(AdrW'(r_entries)), .i_wdata({r_sum, r_a, r_b}),
        .i_raddr(AdrW'(r_k)), .o_rdata(w_ent));

    assign {e_sum, e_l, e_r} = w_ent;

    assign o_status.walk_done = (r_count < CntW'(2)) ||
        ((CntW'(r_i) == r_count - CntW'(2)) && (CntW'(r_j) == r_count - CntW'(1)));
    assign o_status.scan_done = (r_k == r_entries);
    assign o_status.sum_hit   = (e_sum == r_sum);
    assign o_status.disjoint  = (e_l != r_a) && (e_l != r_b) && (e_r != r_a) && (e_r != r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0; r_ovf <= 1'b0; r_found <= 1'b0;
            r_fl <= '0; r_fr <= '0; r_sl <= '0; r_sr <= '0;
            r_entries <= '0; r_i <= '0; r_j <= IdxW'(1); r_k <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_count < CntW'(MAX_ELEMENTS)) r_count <= r_count + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (i_cmd.start_walk) begin
                r_i <= '0; r_j <= IdxW'(1); r_entries <= '0;
            end
            if (i_cmd.read_pair) begin
                r_a <= w_a; r_b <= w_b;
                r_sum <= SumW'(signed'(w_a)) + SumW'(signed'(w_b));
                r_k <= '0;
            end
            if (i_cmd.scan_step) r_k <= r_k + 1'b1;
            if (i_cmd.record) begin
                if (r_entries < EntW'(MAX_SUM_ENTRIES)) r_entries <= r_entries + 1'b1;
            end
            if (i_cmd.advance) begin
                if (CntW'(r_j) == r_count - CntW'(1)) begin
                    r_i <= r_i + 1'b1; r_j <= r_i + IdxW'(2);
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (i_cmd.capture) begin
                r_found <= 1'b1; r_fl <= e_l; r_fr <= e_r; r_sl <= r_a; r_sr <= r_b;
            end
        end
    end

    assign o_found = r_found;
    assign o_first_left = r_fl;
    assign o_first_right = r_fr;
    assign o_second_left = r_sl;
    assign o_second_right = r_sr;
    assign o_overflow = r_ovf;
endmodule
`default_nettype wire

>>> design/esp_ctrl.sv
`default_nettype none
module esp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_last,
    input  wire esp_pkg::t_status i_status,
    output esp_pkg::t_cmd         o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);
    import esp_pkg::*;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_RDREQ = 8'b0000_0100,
        S_PAIR  = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_TEST  = 8'b0010_0000,
        S_NEXT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   is_last;

    assign is_last = i_status.walk_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.start_walk = 1'b1;
                n_state = S_RDREQ;
            end
            S_RDREQ: n_state = S_PAIR;
            S_PAIR: begin
                o_cmd.read_pair = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Entry k is being read; its data is tested next cycle.
                if (i_status.scan_done) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.sum_hit) begin
                    if (i_status.disjoint) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_DONE;
                    end else if (is_last) begin
                        n_state = S_DONE;
                    end else begin
                        // The sum is already held, so only the pair moves on.
                        o_cmd.advance = 1'b1;
                        n_state = S_RDREQ;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_NEXT: begin
                if (is_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.record = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state = S_RDREQ;
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                o_cmd.clear = 1'b1;
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned SUM_SLOTS = 120;
    localparam int unsigned N_RANDOM = 1850;

    typedef struct {
        logic               found;
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic signed [15:0] sl;
        logic signed [15:0] sr;
        logic               ovf;
    } t_result;

    typedef struct {
        logic signed [15:0] val;
        logic               last;
        bit                 typed;
        t_result            exp;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_element_value;
    logic               i_last_element;
    logic               o_valid;
    logic               o_pair_found;
    logic signed [15:0] o_first_left;
    logic signed [15:0] o_first_right;
    logic signed [15:0] o_second_left;
    logic signed [15:0] o_second_right;
    logic               o_list_overflow;

    equal_sum_pair_finder_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element_value(i_element_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .o_pair_found   (o_pair_found),
        .o_first_left   (o_first_left),
        .o_first_right  (o_first_right),
        .o_second_left  (o_second_left),
        .o_second_right (o_second_right),
        .o_list_overflow(o_list_overflow)
    );

    // Shadow copy of the list being loaded.
    logic signed [15:0] list_vals [CAPACITY];
    int unsigned        list_len;
    bit                 list_dropped;

    t_result     pending_reports[$];
    t_row        dir_tab[$];
    int unsigned n_errors;
    int unsigned n_reports;
    int unsigned n_found;
    int unsigned n_requests;
    int unsigned n_lists;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300_000_000;
        $display("Timeout with %0d reports still pending.", pending_reports.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_result pair_search();
        t_result            r;
        int                 sums [SUM_SLOTS];
        logic signed [15:0] lhs [SUM_SLOTS];
        logic signed [15:0] rhs [SUM_SLOTS];
        int unsigned        n_sums;
        int                 a;
        int                 b;
        int                 s;
        int                 hit;
        r = '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, list_dropped};
        n_sums = 0;
        for (int i = 0; i < list_len && !r.found; i++) begin
            for (int j = i + 1; j < list_len && !r.found; j++) begin
                a = list_vals[i];
                b = list_vals[j];
                s = a + b;
                hit = -1;
                for (int k = 0; k < n_sums; k++) begin
                    if (hit < 0 && sums[k] == s) hit = k;
                end
                if (hit >= 0) begin
                    if (lhs[hit] != a && lhs[hit] != b && rhs[hit] != a && rhs[hit] != b) begin
                        r.found = 1'b1;
                        r.fl = lhs[hit];
                        r.fr = rhs[hit];
                        r.sl = a;
                        r.sr = b;
                    end
                end else if (n_sums < SUM_SLOTS) begin
                    sums[n_sums] = s;
                    lhs[n_sums] = a;
                    rhs[n_sums] = b;
                    n_sums++;
                end
            end
        end
        return r;
    endfunction

    // Drives one request and updates the shadow list once it is taken.
    task automatic send_request(input t_row row);
        t_result r;
        repeat ($urandom_range(0, 8)) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_element_value = row.val;
        i_last_element = row.last;
        do @(posedge i_clk); while (busy);
        n_requests++;
        if (list_len < CAPACITY) begin
            list_vals[list_len] = row.val;
            list_len++;
        end else begin
            list_dropped = 1'b1;
        end
        if (row.last) begin
            r = pair_search();
            pending_reports.push_back(row.typed ? row.exp : r);
            list_len = 0;
            list_dropped = 1'b0;
            n_lists++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            n_reports++;
            if (o_pair_found) n_found++;
            if (pending_reports.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("Unexpected report at %0t", $realtime);
            end else begin
                e = pending_reports.pop_front();
                if (o_pair_found !== e.found || o_first_left !== e.fl
                        || o_first_right !== e.fr || o_second_left !== e.sl
                        || o_second_right !== e.sr || o_list_overflow !== e.ovf) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("Mismatch at %0t: expected %0b %0d %0d %0d %0d %0b", $realtime,
                                 e.found, e.fl, e.fr, e.sl, e.sr, e.ovf);
                        $display("                 got      %0b %0d %0d %0d %0d %0b",
                                 o_pair_found, o_first_left, o_first_right, o_second_left,
                                 o_second_right, o_list_overflow);
                    end
                end
            end
        end
    end

    function automatic void add_row(input int v, input bit last, input bit typed = 0,
                                    input t_result exp = '{0, 0, 0, 0, 0, 0});
        t_row row;
        row.val = 16'(v);
        row.last = last;
        row.typed = typed;
        row.exp = exp;
        dir_tab.push_back(row);
    endfunction

    function automatic logic signed [15:0] draw_value(input int unsigned mode);
        case (mode)
            0: return 16'($urandom_range(0, 12) - 6);
            1: return 16'($urandom());
            default: begin
                case ($urandom_range(0, 5))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    4: return 16'sd1;
                    default: return 16'($urandom());
                endcase
            end
        endcase
    endfunction

    initial begin
        t_row        row;
        int unsigned len;
        int unsigned mode;
        int unsigned pick;
        start = 1'b0;
        i_element_value = '0;
        i_last_element = 1'b0;
        i_rst_n = 1'b0;
        list_len = 0;
        list_dropped = 1'b0;
        n_errors = 0;
        n_reports = 0;
        n_found = 0;
        n_requests = 0;
        n_lists = 0;

        // A single element cannot form two pairs.
        add_row(7, 1, 1, '{0, 0, 0, 0, 0, 0});
        // 1+4 is stored first, then 2+3 matches it.
        add_row(1, 0); add_row(2, 0); add_row(3, 0);
        add_row(4, 1, 1, '{1, 1, 4, 2, 3, 0});
        // Extremes: the sum -1 recurs as max+min and -1+0.
        add_row(32767, 0); add_row(-32768, 0); add_row(-1, 0);
        add_row(0, 1, 1, '{1, 32767, -32768, -1, 0, 0});
        // Every pair shares the value 5, so nothing matches.
        add_row(5, 0); add_row(5, 0); add_row(5, 0);
        add_row(5, 1, 1, '{0, 0, 0, 0, 0, 0});
        // Seventeen requests overflow the list; the last one is dropped.
        for (int k = 0; k < 16; k++) add_row(k * 1000 - 7, 0);
        add_row(3, 1);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) send_request(dir_tab[k]);

        while (n_requests < N_RANDOM + dir_tab.size()) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) len = $urandom_range(1, 8);
            else if (pick < 18) len = $urandom_range(9, 16);
            else len = $urandom_range(17, 20);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < len; k++) begin
                row.val = draw_value(mode);
                row.last = (k == len - 1);
                row.typed = 0;
                send_request(row);
            end
        end
        @(negedge i_clk);
        start = 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d requests in %0d lists; %0d reports, %0d with a matching pair.",
                 n_requests, n_lists, n_reports, n_found);
        $display("Mismatches: %0d.", n_errors);
        if (n_errors == 0 && pending_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
